[rtl/precharge_power_sequencer_unit_defines.svh]
// Assertion macros shared by the precharge power sequencer RTL.
`ifndef PRECHARGE_POWER_SEQUENCER_UNIT_DEFINES_SVH
`define PRECHARGE_POWER_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PPS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/pps_pkg.sv]
// Shared types and constants of the precharge power sequencer.
package pps_pkg;

    localparam int TIME_WIDTH = 32;
    localparam int CFG_WIDTH  = 32;
    localparam int IDX_WIDTH  = 3;

    // Configuration register indexes.
    localparam logic [IDX_WIDTH-1:0] CFG_PRECHARGE_TIME    = 3'd0;
    localparam logic [IDX_WIDTH-1:0] CFG_CLOSE_SETTLE_TIME = 3'd1;
    localparam logic [IDX_WIDTH-1:0] CFG_STABILIZE_TIME    = 3'd2;
    localparam logic [IDX_WIDTH-1:0] CFG_OPEN_SETTLE_TIME  = 3'd3;
    localparam logic [IDX_WIDTH-1:0] CFG_DISCHARGE_TIME    = 3'd4;

    // Configuration reset values, in microseconds.
    localparam logic [CFG_WIDTH-1:0] RST_PRECHARGE_TIME    = 32'd3000000;
    localparam logic [CFG_WIDTH-1:0] RST_CLOSE_SETTLE_TIME = 32'd500000;
    localparam logic [CFG_WIDTH-1:0] RST_STABILIZE_TIME    = 32'd1000000;
    localparam logic [CFG_WIDTH-1:0] RST_OPEN_SETTLE_TIME  = 32'd500000;
    localparam logic [CFG_WIDTH-1:0] RST_DISCHARGE_TIME    = 32'd8000000;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_PRECHARGE = 3'd1,
        PH_CLOSE     = 3'd2,
        PH_RUNNING   = 3'd3,
        PH_STABILIZE = 3'd4,
        PH_OPEN      = 3'd5,
        PH_DISCHARGE = 3'd6
    } t_phase;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] precharge_time;
        logic [CFG_WIDTH-1:0] close_settle_time;
        logic [CFG_WIDTH-1:0] stabilize_time;
        logic [CFG_WIDTH-1:0] open_settle_time;
        logic [CFG_WIDTH-1:0] discharge_time;
    } t_cfg;

    typedef struct packed {
        t_phase                phase;
        logic [TIME_WIDTH-1:0] start;
        logic                  led;
        logic                  precharge;
        logic                  contactor;
        logic                  discharge;
        logic                  rails;
    } t_state;

endpackage

[rtl/precharge_power_sequencer_unit.sv]
// Top level of the precharge power sequencer: input register, step logic, result register.
//
// Each input transaction is one poll carrying the microsecond time and the remote switch
// level; each poll yields exactly one result transaction with the phase and the relay,
// discharge, rail and LED drives after that step. A poll passes the input register, then
// the result register, and a new poll is accepted every cycle, because the whole step is
// one wrapping subtract, one compare against the selected timeout register and the phase
// update. The input side is stalled only while a poll is waiting in the input register
// and the result register is full and stalled. The user must write timeout registers
// through the write port only while no poll is in flight; the block does not enforce it.
`include "precharge_power_sequencer_unit_defines.svh"

module precharge_power_sequencer_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write port.
    input  logic                           i_cfg_we,
    input  logic [pps_pkg::IDX_WIDTH-1:0]  i_cfg_index,
    input  logic [pps_pkg::CFG_WIDTH-1:0]  i_cfg_data,
    // Poll input channel.
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [31:0]                    i_time_now,
    input  logic                           i_remote_open,
    // Result channel.
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [2:0]                     o_phase,
    output logic                           o_precharge_relay,
    output logic                           o_contactor_relay,
    output logic                           o_discharge_on,
    output logic                           o_rails_on,
    output logic                           o_led
);

    pps_pkg::t_cfg                  cfg;
    pps_pkg::t_state                r_state;
    pps_pkg::t_state                n_state;

    logic                           r_in_valid;
    logic [pps_pkg::TIME_WIDTH-1:0] r_time;
    logic                           r_remote_open;
    logic                           r_out_valid;
    logic                           advance;
    logic                           in_accept;

    pps_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // The buffered poll moves into the result register when that register is free
    // or is being emptied in this cycle; the sequencer state steps at the same edge.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_time        <= i_time_now[pps_pkg::TIME_WIDTH-1:0];
            r_remote_open <= i_remote_open;
        end
    end

    pps_step u_step (
        .i_state       (r_state),
        .i_cfg         (cfg),
        .i_now         (r_time),
        .i_remote_open (r_remote_open),
        .o_state       (n_state)
    );

    // The sequencer state doubles as the result register payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase     <= pps_pkg::PH_IDLE;
            r_state.start     <= '0;
            r_state.led       <= 1'b0;
            r_state.precharge <= 1'b0;
            r_state.contactor <= 1'b0;
            r_state.discharge <= 1'b0;
            r_state.rails     <= 1'b0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_phase           = r_state.phase;
    assign o_precharge_relay = r_state.precharge;
    assign o_contactor_relay = r_state.contactor;
    assign o_discharge_on    = r_state.discharge;
    assign o_rails_on        = r_state.rails;
    assign o_led             = r_state.led;

    // Discharge never runs into a closed main contactor.
    `PPS_ASSERT_SAME(a_no_discharge_on_contactor, i_clk, i_rst_n,
        o_out_valid, !(o_contactor_relay && o_discharge_on), "discharge with contactor closed")
    // Rails are on only from running through discharging.
    `PPS_ASSERT_SAME(a_rails_phase, i_clk, i_rst_n, o_out_valid && o_rails_on,
        o_phase == pps_pkg::PH_RUNNING || o_phase == pps_pkg::PH_OPEN ||
        o_phase == pps_pkg::PH_DISCHARGE, "rails on outside powered phases")
    // The input side stalls only behind a full, stalled result register.
    `PPS_ASSERT_SAME(a_stall_cause, i_clk, i_rst_n, o_in_stall,
        o_out_valid && i_out_stall, "input stalled without output backpressure")
    // A taken result with nothing buffered leaves the result register empty.
    `PPS_ASSERT_NEXT(a_drain, i_clk, i_rst_n, o_out_valid && !i_out_stall && !r_in_valid,
        !o_out_valid, "result repeated after transaction")

endmodule

[rtl/pps_cfg_regs.sv]
// Timeout configuration registers of the precharge power sequencer.
module pps_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pps_pkg::IDX_WIDTH-1:0]  i_cfg_index,
    input  logic [pps_pkg::CFG_WIDTH-1:0]  i_cfg_data,
    output pps_pkg::t_cfg                  o_cfg
);

    pps_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.precharge_time    <= pps_pkg::RST_PRECHARGE_TIME;
            r_cfg.close_settle_time <= pps_pkg::RST_CLOSE_SETTLE_TIME;
            r_cfg.stabilize_time    <= pps_pkg::RST_STABILIZE_TIME;
            r_cfg.open_settle_time  <= pps_pkg::RST_OPEN_SETTLE_TIME;
            r_cfg.discharge_time    <= pps_pkg::RST_DISCHARGE_TIME;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pps_pkg::CFG_PRECHARGE_TIME:    r_cfg.precharge_time    <= i_cfg_data;
                pps_pkg::CFG_CLOSE_SETTLE_TIME: r_cfg.close_settle_time <= i_cfg_data;
                pps_pkg::CFG_STABILIZE_TIME:    r_cfg.stabilize_time    <= i_cfg_data;
                pps_pkg::CFG_OPEN_SETTLE_TIME:  r_cfg.open_settle_time  <= i_cfg_data;
                pps_pkg::CFG_DISCHARGE_TIME:    r_cfg.discharge_time    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/pps_step.sv]
// Next-state logic of the sequencer for one poll transaction.
module pps_step (
    input  pps_pkg::t_state                i_state,
    input  pps_pkg::t_cfg                  i_cfg,
    input  logic [pps_pkg::TIME_WIDTH-1:0] i_now,
    input  logic                           i_remote_open,
    output pps_pkg::t_state                o_state
);

    logic [pps_pkg::TIME_WIDTH-1:0] diff;
    logic [pps_pkg::CFG_WIDTH-1:0]  limit;
    logic                           elapsed;

    // Elapsed time wraps at the timer width.
    assign diff = i_now - i_state.start;

    always_comb begin
        case (i_state.phase)
            pps_pkg::PH_PRECHARGE: limit = i_cfg.precharge_time;
            pps_pkg::PH_CLOSE:     limit = i_cfg.close_settle_time;
            pps_pkg::PH_STABILIZE: limit = i_cfg.stabilize_time;
            pps_pkg::PH_OPEN:      limit = i_cfg.open_settle_time;
            pps_pkg::PH_DISCHARGE: limit = i_cfg.discharge_time;
            default:               limit = i_cfg.precharge_time;
        endcase
    end

    assign elapsed = diff > limit;

    always_comb begin
        o_state = i_state;
        case (i_state.phase)
            pps_pkg::PH_IDLE: begin
                if (!i_remote_open) begin
                    o_state.start     = i_now;
                    o_state.phase     = pps_pkg::PH_PRECHARGE;
                    o_state.discharge = 1'b0;
                    o_state.precharge = 1'b1;
                    o_state.led       = 1'b1;
                end
            end
            pps_pkg::PH_PRECHARGE: begin
                o_state.led = ~i_state.led;
                if (elapsed) begin
                    o_state.start     = i_now;
                    o_state.phase     = pps_pkg::PH_CLOSE;
                    o_state.led       = 1'b1;
                    o_state.contactor = 1'b1;
                end
            end
            pps_pkg::PH_CLOSE: begin
                if (elapsed) begin
                    o_state.start     = i_now;
                    o_state.phase     = pps_pkg::PH_STABILIZE;
                    o_state.precharge = 1'b0;
                end
            end
            pps_pkg::PH_STABILIZE: begin
                if (elapsed) begin
                    o_state.start = i_now;
                    o_state.phase = pps_pkg::PH_RUNNING;
                    o_state.rails = 1'b1;
                end
            end
            pps_pkg::PH_RUNNING: begin
                if (i_remote_open) begin
                    o_state.start     = i_now;
                    o_state.phase     = pps_pkg::PH_OPEN;
                    o_state.contactor = 1'b0;
                end
            end
            pps_pkg::PH_OPEN: begin
                if (elapsed) begin
                    o_state.start     = i_now;
                    o_state.phase     = pps_pkg::PH_DISCHARGE;
                    o_state.discharge = 1'b1;
                end
            end
            pps_pkg::PH_DISCHARGE: begin
                o_state.led = ~i_state.led;
                if (elapsed) begin
                    o_state.led       = 1'b0;
                    o_state.discharge = 1'b0;
                    o_state.phase     = pps_pkg::PH_IDLE;
                    o_state.rails     = 1'b0;
                end
            end
            default: begin
                // Illegal phase code: drop both relays and discharge, go idle.
                o_state.precharge = 1'b0;
                o_state.contactor = 1'b0;
                o_state.discharge = 1'b0;
                o_state.phase     = pps_pkg::PH_IDLE;
            end
        endcase
    end

endmodule

[tb/precharge_power_sequencer_unit_tb.sv]
// Self-checking testbench for the precharge power sequencer: driver, predictor and monitor.
`timescale 1ns / 1ps

module precharge_power_sequencer_unit_tb;

    // A run is declared hung when this many cycles pass with no transaction on
    // either channel and no register write. The longest legal quiet stretch is a
    // sender gap, a receiver stall and the pass through both registers, far below this.
    localparam int QUIET_LIMIT = 5000;
    localparam int SETTINGS_COUNT = 10;
    localparam int POLLS_PER_SETTING = 103;

    typedef logic [pps_pkg::IDX_WIDTH-1:0]  t_idx;
    typedef logic [pps_pkg::TIME_WIDTH-1:0] t_time;
    typedef logic [pps_pkg::CFG_WIDTH-1:0]  t_word;

    localparam t_idx TIMEOUT_REGS [5] = '{
        pps_pkg::CFG_PRECHARGE_TIME, pps_pkg::CFG_CLOSE_SETTLE_TIME,
        pps_pkg::CFG_STABILIZE_TIME, pps_pkg::CFG_OPEN_SETTLE_TIME,
        pps_pkg::CFG_DISCHARGE_TIME
    };

    localparam t_word TIMEOUT_RESETS [5] = '{
        pps_pkg::RST_PRECHARGE_TIME, pps_pkg::RST_CLOSE_SETTLE_TIME,
        pps_pkg::RST_STABILIZE_TIME, pps_pkg::RST_OPEN_SETTLE_TIME,
        pps_pkg::RST_DISCHARGE_TIME
    };

    // One poll as it is offered on the input channel.
    typedef struct {
        t_time time_now;
        logic  remote_open;
    } t_poll;

    // The drive levels that one poll should produce on the result channel.
    typedef struct {
        logic [2:0] phase;
        logic       precharge_relay;
        logic       contactor_relay;
        logic       discharge_on;
        logic       rails_on;
        logic       led;
    } t_relay_drive;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    t_idx                  i_cfg_index = '0;
    t_word                 i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [31:0]           i_time_now = '0;
    logic                  i_remote_open = 1'b1;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [2:0]            o_phase;
    logic                  o_precharge_relay;
    logic                  o_contactor_relay;
    logic                  o_discharge_on;
    logic                  o_rails_on;
    logic                  o_led;

    // Polls waiting to be offered, and drive levels waiting to be observed.
    t_poll        poll_queue[$];
    t_relay_drive expected_drives[$];

    // Predicted sequencer state and timeout registers, advanced at each accepted
    // transaction and each register write.
    pps_pkg::t_state seq_now;
    pps_pkg::t_cfg   cfg_now;

    logic poll_taken = 1'b0;
    logic idling_on = 1'b1;
    int   gap_left = 0;
    int   stall_left = 0;
    int   polls_planned = 0;
    int   polls_taken = 0;
    int   results_seen = 0;
    int   fail_count = 0;
    int   cycles_done = 0;
    int   settings_applied = 1;
    int   quiet_cycles = 0;

    precharge_power_sequencer_unit u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_time_now        (i_time_now),
        .i_remote_open     (i_remote_open),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_phase           (o_phase),
        .o_precharge_relay (o_precharge_relay),
        .o_contactor_relay (o_contactor_relay),
        .o_discharge_on    (o_discharge_on),
        .o_rails_on        (o_rails_on),
        .o_led             (o_led)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // A phase timeout has passed once the wrapped time since the phase began is
    // strictly greater than the register.
    function automatic bit timeout_passed(input t_time now, input t_time start,
                                          input t_word limit);
        return (now - start) > limit;
    endfunction

    // One poll of the sequencer: returns the state after the step.
    function automatic pps_pkg::t_state sequencer_step(input pps_pkg::t_state s,
                                                       input pps_pkg::t_cfg c,
                                                       input t_time now,
                                                       input logic remote_open);
        pps_pkg::t_state n;
        n = s;
        case (s.phase)
            pps_pkg::PH_IDLE: begin
                // Entering precharge lights the LED; it starts blinking next poll.
                if (!remote_open) begin
                    n.start     = now;
                    n.phase     = pps_pkg::PH_PRECHARGE;
                    n.discharge = 1'b0;
                    n.precharge = 1'b1;
                    n.led       = 1'b1;
                end
            end
            pps_pkg::PH_PRECHARGE: begin
                n.led = ~s.led;
                if (timeout_passed(now, s.start, c.precharge_time)) begin
                    n.start     = now;
                    n.phase     = pps_pkg::PH_CLOSE;
                    n.led       = 1'b1;
                    n.contactor = 1'b1;
                end
            end
            pps_pkg::PH_CLOSE: begin
                if (timeout_passed(now, s.start, c.close_settle_time)) begin
                    n.start     = now;
                    n.phase     = pps_pkg::PH_STABILIZE;
                    n.precharge = 1'b0;
                end
            end
            pps_pkg::PH_STABILIZE: begin
                if (timeout_passed(now, s.start, c.stabilize_time)) begin
                    n.start = now;
                    n.phase = pps_pkg::PH_RUNNING;
                    n.rails = 1'b1;
                end
            end
            pps_pkg::PH_RUNNING: begin
                if (remote_open) begin
                    n.start     = now;
                    n.phase     = pps_pkg::PH_OPEN;
                    n.contactor = 1'b0;
                end
            end
            pps_pkg::PH_OPEN: begin
                if (timeout_passed(now, s.start, c.open_settle_time)) begin
                    n.start     = now;
                    n.phase     = pps_pkg::PH_DISCHARGE;
                    n.discharge = 1'b1;
                end
            end
            pps_pkg::PH_DISCHARGE: begin
                // The phase start is left alone on the way back to idle.
                n.led = ~s.led;
                if (timeout_passed(now, s.start, c.discharge_time)) begin
                    n.led       = 1'b0;
                    n.discharge = 1'b0;
                    n.phase     = pps_pkg::PH_IDLE;
                    n.rails     = 1'b0;
                end
            end
            default: begin
                // An illegal phase drops both relays and the discharge, keeping
                // the LED and the rails.
                n.precharge = 1'b0;
                n.contactor = 1'b0;
                n.discharge = 1'b0;
                n.phase     = pps_pkg::PH_IDLE;
            end
        endcase
        return n;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Input driver. A stalled transaction is held unchanged; otherwise the front of
    // the queue is retired if it was taken, and the next one is offered unless a
    // gap burst is running or starts now.
    always @(negedge i_clk) begin : poll_driver
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!(i_in_valid && !poll_taken)) begin
            if (i_in_valid) begin
                poll_queue.delete(0);
            end
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (poll_queue.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                gap_left = $urandom_range(0, 10);
                i_in_valid <= 1'b0;
            end else begin
                i_in_valid    <= 1'b1;
                i_time_now    <= poll_queue[0].time_now;
                i_remote_open <= poll_queue[0].remote_open;
            end
        end
    end

    // Result channel backpressure, applied in random bursts.
    always @(negedge i_clk) begin : result_stall
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (idling_on && $urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(0, 10);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Monitor and scoreboard. Register writes and accepted polls advance the
    // prediction; each accepted result is compared with the oldest expectation.
    always @(posedge i_clk) begin : scoreboard
        pps_pkg::t_state stepped;
        t_relay_drive    want;
        if (!i_rst_n) begin
            seq_now = '0;
            cfg_now = '{pps_pkg::RST_PRECHARGE_TIME, pps_pkg::RST_CLOSE_SETTLE_TIME,
                        pps_pkg::RST_STABILIZE_TIME, pps_pkg::RST_OPEN_SETTLE_TIME,
                        pps_pkg::RST_DISCHARGE_TIME};
            poll_taken <= 1'b0;
        end else begin
            poll_taken <= i_in_valid && !o_in_stall;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    pps_pkg::CFG_PRECHARGE_TIME:    cfg_now.precharge_time    = i_cfg_data;
                    pps_pkg::CFG_CLOSE_SETTLE_TIME: cfg_now.close_settle_time = i_cfg_data;
                    pps_pkg::CFG_STABILIZE_TIME:    cfg_now.stabilize_time    = i_cfg_data;
                    pps_pkg::CFG_OPEN_SETTLE_TIME:  cfg_now.open_settle_time  = i_cfg_data;
                    pps_pkg::CFG_DISCHARGE_TIME:    cfg_now.discharge_time    = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                stepped = sequencer_step(seq_now, cfg_now, i_time_now, i_remote_open);
                if (seq_now.phase == pps_pkg::PH_DISCHARGE
                        && stepped.phase == pps_pkg::PH_IDLE) begin
                    cycles_done++;
                end
                seq_now = stepped;
                expected_drives.push_back('{stepped.phase, stepped.precharge,
                                            stepped.contactor, stepped.discharge,
                                            stepped.rails, stepped.led});
                polls_taken++;
            end
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (expected_drives.size() == 0) begin
                    $error("result transaction arrived with no expected result waiting");
                    fail_count++;
                end else begin
                    want = expected_drives.pop_front();
                    check_field("phase", 32'(want.phase), 32'(o_phase));
                    check_field("precharge_relay", 32'(want.precharge_relay),
                                32'(o_precharge_relay));
                    check_field("contactor_relay", 32'(want.contactor_relay),
                                32'(o_contactor_relay));
                    check_field("discharge_on", 32'(want.discharge_on),
                                32'(o_discharge_on));
                    check_field("rails_on", 32'(want.rails_on), 32'(o_rails_on));
                    check_field("led", 32'(want.led), 32'(o_led));
                end
            end
        end
    end

    // Watchdog on cycles with no traffic at all.
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_poll(input t_time now, input logic remote_open);
        poll_queue.push_back('{now, remote_open});
        polls_planned++;
    endtask

    // Plans polls against a private copy of the predicted state, so that the
    // timed phases mostly get times right at, just past, or inside their timeout
    // and the sequence keeps moving through every phase. The rest is noise.
    task automatic plan_polls(input int count);
        pps_pkg::t_state shadow;
        t_word           limit;
        t_time           now;
        logic            remote_open;
        shadow = seq_now;
        for (int k = 0; k < count; k++) begin
            now = $urandom;
            remote_open = 1'($urandom_range(0, 1));
            case (shadow.phase)
                pps_pkg::PH_IDLE:    remote_open = ($urandom_range(0, 4) == 0);
                pps_pkg::PH_RUNNING: remote_open = ($urandom_range(0, 2) == 0);
                default: begin
                    case (shadow.phase)
                        pps_pkg::PH_PRECHARGE: limit = cfg_now.precharge_time;
                        pps_pkg::PH_CLOSE:     limit = cfg_now.close_settle_time;
                        pps_pkg::PH_STABILIZE: limit = cfg_now.stabilize_time;
                        pps_pkg::PH_OPEN:      limit = cfg_now.open_settle_time;
                        default:               limit = cfg_now.discharge_time;
                    endcase
                    case ($urandom_range(0, 9))
                        0, 1:    now = shadow.start + limit;
                        2, 3, 4: now = shadow.start + limit + 1;
                        5, 6:    now = shadow.start
                                       + t_time'($urandom % ({1'b0, limit} + 33'd1));
                        default: ;
                    endcase
                end
            endcase
            queue_poll(now, remote_open);
            shadow = sequencer_step(shadow, cfg_now, now, remote_open);
        end
    endtask

    // Holds the sender off until every poll has been taken and answered.
    task automatic wait_drained();
        while (polls_taken != polls_planned || results_seen != polls_planned) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    // Starts a write on the current falling edge and returns on the next one.
    task automatic write_reg(input t_idx index, input t_word value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(negedge i_clk);
    endtask

    function automatic t_word random_timeout();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 3);
            1:       return $urandom;
            2:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: return $urandom_range(1, 1000);
        endcase
    endfunction

    // Setting one is all zeros, two is all ones, three is the reset values, and
    // the rest are random mixes. Writes to unused indexes must change nothing.
    task automatic program_timeouts(input int setting);
        int pick;
        pick = $urandom_range(0, 4);
        foreach (TIMEOUT_REGS[r]) begin
            case (setting)
                1: write_reg(TIMEOUT_REGS[r], '0);
                2: write_reg(TIMEOUT_REGS[r], '1);
                3: write_reg(TIMEOUT_REGS[r], TIMEOUT_RESETS[r]);
                default: begin
                    if (r == pick || $urandom_range(0, 2) != 0) begin
                        write_reg(TIMEOUT_REGS[r], random_timeout());
                    end
                end
            endcase
        end
        if (setting == 1) begin
            for (int j = 1; j <= 3; j++) begin
                write_reg(t_idx'(pps_pkg::CFG_DISCHARGE_TIME + j), $urandom);
            end
        end else if ($urandom_range(0, 1) == 0) begin
            write_reg(t_idx'(pps_pkg::CFG_DISCHARGE_TIME + $urandom_range(1, 3)), $urandom);
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin : run_sequence
        t_time t;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed walk through a whole power cycle at the reset timeouts. Precharge
        // begins at the top of the time range so that its timeout wraps through
        // zero, and every timed phase is polled exactly at its limit, where it must
        // stay, and one microsecond later, where it must move on.
        queue_poll(32'h0000_0000, 1'b1);
        queue_poll(32'hFFFF_FFFF, 1'b1);
        queue_poll(32'hFFFF_FFFF, 1'b0);
        queue_poll(32'h0000_0000, 1'b0);
        t = 32'hFFFF_FFFF + pps_pkg::RST_PRECHARGE_TIME;
        queue_poll(t, 1'b1);
        queue_poll(t + 1, 1'b0);
        t = t + 1 + pps_pkg::RST_CLOSE_SETTLE_TIME;
        queue_poll(t, 1'b1);
        queue_poll(t + 1, 1'b0);
        t = t + 1 + pps_pkg::RST_STABILIZE_TIME;
        queue_poll(t, 1'b1);
        queue_poll(t + 1, 1'b1);
        queue_poll(32'h7FFF_FFFF, 1'b0);
        t = 32'h8000_0000;
        queue_poll(t, 1'b1);
        queue_poll(t + pps_pkg::RST_OPEN_SETTLE_TIME, 1'b0);
        queue_poll(t + pps_pkg::RST_OPEN_SETTLE_TIME + 1, 1'b0);
        t = t + pps_pkg::RST_OPEN_SETTLE_TIME + 1;
        queue_poll(t, 1'b1);
        queue_poll(t + pps_pkg::RST_DISCHARGE_TIME, 1'b0);
        queue_poll(t + pps_pkg::RST_DISCHARGE_TIME + 1, 1'b1);
        queue_poll(32'h5555_5555, 1'b1);
        queue_poll(32'h5555_5555, 1'b0);
        queue_poll(32'hAAAA_AAAA, 1'b1);
        wait_drained();

        // Random part. Each setting is programmed with nothing in flight; the
        // sequencer itself may be in any phase, including one it cannot leave
        // while every timeout is at its maximum. The last two run without gaps.
        for (int s = 1; s <= SETTINGS_COUNT; s++) begin
            program_timeouts(s);
            settings_applied++;
            @(posedge i_clk);
            idling_on = (s <= SETTINGS_COUNT - 2) && ($urandom_range(0, 3) != 0);
            plan_polls(POLLS_PER_SETTING);
            wait_drained();
        end

        repeat (10) @(negedge i_clk);
        if (expected_drives.size() != 0) begin
            $error("%0d expected results never arrived", expected_drives.size());
            fail_count++;
        end
        $display("Ran %0d poll transactions under %0d timeout settings.",
                 polls_taken, settings_applied);
        $display("The sequencer went back to idle from discharging %0d times; %0d failures.",
                 cycles_done, fail_count);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
